// ----- rtl/pool2d_pkg.sv -----
// Shared constants and types of the 2-D pooling block.
`timescale 1ns / 1ps

package pool2d_pkg;

    localparam int HEIGHT_LIMIT   = 1024;
    localparam int ROW_BITS       = 10;
    localparam int HEIGHT_BITS    = 11;

    localparam int MODE_BITS      = 2;
    localparam int WSIZE_BITS     = 4;
    localparam int DIM_BITS       = 11;
    localparam int CFG_DATA_BITS  = 11;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [MODE_BITS-1:0] MODE_AVG = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_MAX = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_MIN = 2'd2;

    localparam logic [MODE_BITS-1:0]  POOL_MODE_RESET   = MODE_MAX;
    localparam logic [WSIZE_BITS-1:0] WINDOW_SIZE_RESET = 4'd2;
    localparam logic [DIM_BITS-1:0]   MAP_WIDTH_RESET   = 11'd28;
    localparam logic [DIM_BITS-1:0]   MAP_HEIGHT_RESET  = 11'd28;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_POOL_MODE   = 2'd0,
        REG_WINDOW_SIZE = 2'd1,
        REG_MAP_WIDTH   = 2'd2,
        REG_MAP_HEIGHT  = 2'd3
    } cfg_reg_t;

endpackage

// ----- rtl/pool2d_div.sv -----
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps

module pool2d_div #(
    parameter int DIVIDEND_BITS = 22,
    parameter int DIVISOR_BITS  = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic signed [DIVIDEND_BITS-1:0] dividend,
    input  logic        [DIVISOR_BITS-1:0]  divisor,
    output logic                            done,
    output logic signed [DIVIDEND_BITS-1:0] quotient
);

    localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

    logic [CNT_BITS-1:0]      cnt_reg;
    logic                     done_reg;
    logic [DIVIDEND_BITS-1:0] quot_reg;
    logic [DIVISOR_BITS-1:0]  rem_reg;
    logic [DIVISOR_BITS-1:0]  divisor_reg;
    logic                     neg_reg;

    logic [DIVIDEND_BITS-1:0] dividend_mag;
    logic [DIVISOR_BITS:0]    trial;
    logic [DIVISOR_BITS:0]    diff;
    logic                     fits;

    assign dividend_mag = dividend[DIVIDEND_BITS-1] ? (~unsigned'(dividend)) + DIVIDEND_BITS'(1)
                                                    : unsigned'(dividend);
    assign trial = {rem_reg, quot_reg[DIVIDEND_BITS-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == CNT_BITS'(1));
            if (start) begin
                cnt_reg <= CNT_BITS'(DIVIDEND_BITS);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg    <= dividend_mag;
            rem_reg     <= '0;
            divisor_reg <= divisor;
            neg_reg     <= dividend[DIVIDEND_BITS-1];
        end else if (cnt_reg != '0) begin
            quot_reg <= {quot_reg[DIVIDEND_BITS-2:0], fits};
            rem_reg  <= fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = signed'(neg_reg ? (~quot_reg) + DIVIDEND_BITS'(1) : quot_reg);

endmodule

// ----- rtl/pooling_2d_forward.sv -----
// Top level of the non-overlapping 2-D max, min and average pooling block.
//
//   Channel   Direction  Transaction
//   s_        in         one Q8.8 sample in raster order, tdata = sample_value
//   m_        out        one pooled result, tdata = pooled_value, tlast = last_of_map
//   cfg_      in         register write: cfg_index selects, cfg_data carries the value
//
// One sample is taken at a time. A sample outside every whole window only moves the
// counters, a sample that only updates its column entry passes through S_CALC (line
// store read, then write back), a max or min result goes on through S_EMIT, and an
// average result through S_DIV, where the bit-serial divider runs, and then S_EMIT.
// A new sample is taken while a result still waits in the output register; a further
// result waits for it. Reset clears the counters and restores the register defaults;
// the line store is not cleared, since every window writes its entry on its first row.
`timescale 1ns / 1ps

module pooling_2d_forward
    import pool2d_pkg::*;
#(
    parameter int MAX_MAP_WIDTH = 1024,
    parameter int MAX_WINDOW    = 8,
    parameter int SAMPLE_BITS   = 16
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // Fields from bit 0: sample_value.
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // Fields from bit 0: pooled_value.
    output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    output logic                                     m_tlast,
    input  logic                                     cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]                cfg_index,
    input  logic [CFG_DATA_BITS-1:0]                 cfg_data
);

    localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int KW         = $clog2(MAX_WINDOW + 1);
    localparam int AREA_BITS  = 2 * KW;
    localparam int WIN_BITS   = $clog2(MAX_WINDOW);
    localparam int COL_BITS   = $clog2(MAX_MAP_WIDTH);
    localparam int WBITS      = $clog2(MAX_MAP_WIDTH + 1);
    localparam int STORE_BITS = SAMPLE_BITS + 2 * $clog2(MAX_WINDOW);
    localparam int CEXT       = ((COL_BITS > KW) ? COL_BITS : KW) + 2;
    localparam int REXT       = ((ROW_BITS > KW) ? ROW_BITS : KW) + 2;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CALC = 4'b0010,
        S_DIV  = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [MODE_BITS-1:0]  pool_mode_reg;
    logic [WSIZE_BITS-1:0] window_size_reg;
    logic [DIM_BITS-1:0]   map_width_reg;
    logic [DIM_BITS-1:0]   map_height_reg;

    logic [COL_BITS-1:0] col_pos_reg;
    logic [ROW_BITS-1:0] row_pos_reg;
    logic [COL_BITS-1:0] out_col_reg;
    logic [WIN_BITS-1:0] col_in_win_reg;
    logic [WIN_BITS-1:0] row_in_win_reg;

    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          first_reg;
    logic                          last_win_reg;
    logic                          last_map_reg;
    logic [COL_BITS-1:0]           addr_reg;
    logic [SAMPLE_BITS-1:0]        res_reg;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [TDATA_BITS-1:0] m_tdata_reg;
    logic                  m_tlast_reg;

    logic signed [STORE_BITS-1:0] store_mem [MAX_MAP_WIDTH];
    logic signed [STORE_BITS-1:0] rd_data_reg;

    logic [KW-1:0]          k_eff;
    logic [WBITS-1:0]       w_eff;
    logic [HEIGHT_BITS-1:0] h_eff;
    logic [AREA_BITS-1:0]   area;

    logic [COL_BITS-1:0] col_base;
    logic [ROW_BITS-1:0] row_base;
    logic [CEXT-1:0]     col_end;
    logic [REXT-1:0]     row_end;
    logic                col_fit, row_fit, col_final, row_final;
    logic                win_first, win_last;
    logic                row_done, map_done, ciw_wrap, riw_wrap;

    logic                          s_accept;
    logic                          out_load;
    logic                          is_avg;
    logic signed [STORE_BITS-1:0]  sample_ext;
    logic signed [STORE_BITS-1:0]  acc;
    logic                          div_start;
    logic                          div_done;
    logic signed [STORE_BITS-1:0]  div_quotient;

    // Clamped register values.
    always_comb begin
        if (window_size_reg == '0) begin
            k_eff = KW'(1);
        end else if (int'(window_size_reg) > MAX_WINDOW) begin
            k_eff = KW'(MAX_WINDOW);
        end else begin
            k_eff = KW'(window_size_reg);
        end
        if (map_width_reg == '0) begin
            w_eff = WBITS'(1);
        end else if (int'(map_width_reg) > MAX_MAP_WIDTH) begin
            w_eff = WBITS'(MAX_MAP_WIDTH);
        end else begin
            w_eff = WBITS'(map_width_reg);
        end
        if (map_height_reg == '0) begin
            h_eff = HEIGHT_BITS'(1);
        end else if (int'(map_height_reg) > HEIGHT_LIMIT) begin
            h_eff = HEIGHT_BITS'(HEIGHT_LIMIT);
        end else begin
            h_eff = HEIGHT_BITS'(map_height_reg);
        end
    end

    assign area = AREA_BITS'(k_eff) * AREA_BITS'(k_eff);

    // A window counts only if it ends inside the map; it is the last one of its
    // row or column band if a further window would not fit.
    assign col_base  = col_pos_reg - COL_BITS'(col_in_win_reg);
    assign row_base  = row_pos_reg - ROW_BITS'(row_in_win_reg);
    assign col_end   = CEXT'(col_base) + CEXT'(k_eff);
    assign row_end   = REXT'(row_base) + REXT'(k_eff);
    assign col_fit   = col_end <= CEXT'(w_eff);
    assign row_fit   = row_end <= REXT'(h_eff);
    assign col_final = (col_end + CEXT'(k_eff)) > CEXT'(w_eff);
    assign row_final = (row_end + REXT'(k_eff)) > REXT'(h_eff);
    assign win_first = (col_in_win_reg == '0) && (row_in_win_reg == '0);
    assign win_last  = (KW'(col_in_win_reg) == k_eff - KW'(1)) &&
                       (KW'(row_in_win_reg) == k_eff - KW'(1));

    assign row_done = (WBITS'(col_pos_reg) + WBITS'(1)) >= w_eff;
    assign map_done = (HEIGHT_BITS'(row_pos_reg) + HEIGHT_BITS'(1)) >= h_eff;
    assign ciw_wrap = (KW'(col_in_win_reg) + KW'(1)) >= k_eff;
    assign riw_wrap = (KW'(row_in_win_reg) + KW'(1)) >= k_eff;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_load = (state_reg == S_EMIT) && (!m_tvalid_reg || m_tready);
    assign is_avg   = (pool_mode_reg != MODE_MAX) && (pool_mode_reg != MODE_MIN);

    // Combine the sample with the column entry read in the cycle of acceptance.
    assign sample_ext = STORE_BITS'(sample_reg);
    always_comb begin
        if (first_reg) begin
            acc = sample_ext;
        end else begin
            case (pool_mode_reg)
                MODE_MAX: acc = (sample_ext > rd_data_reg) ? sample_ext : rd_data_reg;
                MODE_MIN: acc = (sample_ext < rd_data_reg) ? sample_ext : rd_data_reg;
                default:  acc = rd_data_reg + sample_ext;
            endcase
        end
    end

    assign div_start = (state_reg == S_CALC) && last_win_reg && is_avg;

    pool2d_div #(
        .DIVIDEND_BITS (STORE_BITS),
        .DIVISOR_BITS  (AREA_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc),
        .divisor  (area),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_accept && col_fit && row_fit) begin
                    state_next = S_CALC;
                end
            end
            S_CALC: begin
                if (!last_win_reg) begin
                    state_next = S_IDLE;
                end else if (is_avg) begin
                    state_next = S_DIV;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_mode_reg   <= POOL_MODE_RESET;
            window_size_reg <= WINDOW_SIZE_RESET;
            map_width_reg   <= MAP_WIDTH_RESET;
            map_height_reg  <= MAP_HEIGHT_RESET;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_POOL_MODE:   pool_mode_reg   <= cfg_data[MODE_BITS-1:0];
                REG_WINDOW_SIZE: window_size_reg <= cfg_data[WSIZE_BITS-1:0];
                REG_MAP_WIDTH:   map_width_reg   <= cfg_data[DIM_BITS-1:0];
                REG_MAP_HEIGHT:  map_height_reg  <= cfg_data[DIM_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Position counters; a register write restarts the map.
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we) begin
            col_pos_reg    <= '0;
            row_pos_reg    <= '0;
            out_col_reg    <= '0;
            col_in_win_reg <= '0;
            row_in_win_reg <= '0;
        end else if (s_accept) begin
            if (row_done) begin
                col_pos_reg    <= '0;
                out_col_reg    <= '0;
                col_in_win_reg <= '0;
                if (map_done) begin
                    row_pos_reg    <= '0;
                    row_in_win_reg <= '0;
                end else begin
                    row_pos_reg    <= row_pos_reg + ROW_BITS'(1);
                    row_in_win_reg <= riw_wrap ? '0 : row_in_win_reg + WIN_BITS'(1);
                end
            end else begin
                col_pos_reg <= col_pos_reg + COL_BITS'(1);
                if (ciw_wrap) begin
                    col_in_win_reg <= '0;
                    out_col_reg    <= out_col_reg + COL_BITS'(1);
                end else begin
                    col_in_win_reg <= col_in_win_reg + WIN_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            sample_reg   <= signed'(s_tdata[SAMPLE_BITS-1:0]);
            first_reg    <= win_first;
            last_win_reg <= win_last;
            last_map_reg <= col_final && row_final;
            addr_reg     <= out_col_reg;
        end
        if (state_reg == S_CALC) begin
            res_reg <= acc[SAMPLE_BITS-1:0];
        end else if (state_reg == S_DIV && div_done) begin
            res_reg <= div_quotient[SAMPLE_BITS-1:0];
        end
        if (out_load) begin
            m_tdata_reg <= TDATA_BITS'(res_reg);
            m_tlast_reg <= last_map_reg;
        end
    end

    // Line store: one partial result per output column.
    always_ff @(posedge aclk) begin
        if (state_reg == S_CALC) begin
            store_mem[addr_reg] <= acc;
        end
        rd_data_reg <= store_mem[out_col_reg];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ----- rtl/pool2d_checker.sv -----
// Port-level assertions for the pooling block and their binding to the top level.
`timescale 1ns / 1ps

module pool2d_checker #(
    parameter int TDATA_BITS = 16
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [TDATA_BITS-1:0] m_tdata,
    input logic                  m_tlast
);

    // A stalled result transaction keeps its valid and its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // Reset leaves no result pending.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A new result is loaded only while the input side is closed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while input side was open");

    // The input side closes before a result appears.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared right after a sample");

endmodule

bind pooling_2d_forward pool2d_checker #(
    .TDATA_BITS (((SAMPLE_BITS + 7) / 8) * 8)
) u_pool2d_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ----- tb/tb.sv -----
// Self-checking testbench for pooling_2d_forward with a predicting scoreboard.
`timescale 1ns / 1ps

module tb;
    import pool2d_pkg::*;

    localparam int MAP_WIDTH_MAX = 1024;
    localparam int WINDOW_MAX    = 8;
    localparam int LINE_DRAIN    = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_ITEMS  = 1450;
    localparam int CALM_ITEMS    = 120;

    localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [15:0] value;
        logic        last;
    } pooled_t;

    class pool_scoreboard;
        logic [MODE_BITS-1:0]  mode;
        logic [WSIZE_BITS-1:0] wsize;
        logic [DIM_BITS-1:0]   width;
        logic [DIM_BITS-1:0]   height;
        longint                line_acc [MAP_WIDTH_MAX];
        int unsigned           col, row, ocol, cwin, rwin;
        pooled_t               pooled_q [$];
        int                    errors;

        function new();
            mode   = POOL_MODE_RESET;
            wsize  = WINDOW_SIZE_RESET;
            width  = MAP_WIDTH_RESET;
            height = MAP_HEIGHT_RESET;
            errors = 0;
            foreach (line_acc[i]) line_acc[i] = 0;
            restart();
        endfunction

        function void restart();
            col  = 0;
            row  = 0;
            ocol = 0;
            cwin = 0;
            rwin = 0;
        endfunction

        function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function void configure(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_POOL_MODE:   mode   = data[MODE_BITS-1:0];
                REG_WINDOW_SIZE: wsize  = data[WSIZE_BITS-1:0];
                REG_MAP_WIDTH:   width  = data[DIM_BITS-1:0];
                REG_MAP_HEIGHT:  height = data[DIM_BITS-1:0];
                default: ;
            endcase
            restart();
        endfunction

        function void absorb_sample(logic [15:0] raw);
            int unsigned k, w, h, ow, oh;
            longint      x, acc, res;
            pooled_t     r;
            k  = clamp(wsize, 1, WINDOW_MAX);
            w  = clamp(width, 1, MAP_WIDTH_MAX);
            h  = clamp(height, 1, HEIGHT_LIMIT);
            ow = w / k;
            oh = h / k;
            x  = $signed(raw);
            if (col < ow * k && row < oh * k && ocol < MAP_WIDTH_MAX) begin
                if (rwin == 0 && cwin == 0) begin
                    acc = x;
                end else if (mode == MODE_MAX) begin
                    acc = (x > line_acc[ocol]) ? x : line_acc[ocol];
                end else if (mode == MODE_MIN) begin
                    acc = (x < line_acc[ocol]) ? x : line_acc[ocol];
                end else begin
                    acc = line_acc[ocol] + x;
                end
                line_acc[ocol] = acc;
                if (rwin == k - 1 && cwin == k - 1) begin
                    res = acc;
                    if (mode != MODE_MAX && mode != MODE_MIN) res = acc / longint'(k * k);
                    r.value = res[15:0];
                    r.last  = (ocol == ow - 1 && row == oh * k - 1);
                    pooled_q.push_back(r);
                end
            end
            col++;
            if (col >= w) begin
                col  = 0;
                ocol = 0;
                cwin = 0;
                row++;
                rwin++;
                if (rwin >= k) rwin = 0;
                if (row >= h) begin
                    row  = 0;
                    rwin = 0;
                end
            end else begin
                cwin++;
                if (cwin >= k) begin
                    cwin = 0;
                    ocol++;
                end
            end
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10) $display("mismatch: %s", msg);
        endfunction

        function void compare_pooled(logic [15:0] value, logic last);
            pooled_t want;
            if (pooled_q.size() == 0) begin
                report($sformatf("unexpected result value %h last %b", value, last));
                return;
            end
            want = pooled_q.pop_front();
            if (value !== want.value)
                report($sformatf("pooled_value expected %h actual %h", want.value, value));
            if (last !== want.last)
                report($sformatf("last_of_map expected %b actual %b", want.last, last));
        endfunction
    endclass

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [15:0]               s_tdata   = '0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [15:0]               m_tdata;
    logic                      m_tlast;
    logic                      cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    bit             calm     = 1'b0;
    bit             hold_req = 1'b0;
    int unsigned    random_sent = 0;
    pool_scoreboard sb;

    pooling_2d_forward uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("pooling_2d_forward verification failed");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.compare_pooled(m_tdata, m_tlast);
            if (s_tvalid && s_tready) sb.absorb_sample(s_tdata);
        end
    end

    initial begin
        int unsigned gap;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                gap = $urandom_range(1, 18);
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic push_sample(input logic [15:0] v);
        int unsigned gap;
        if (!calm && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 18);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_block();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pooled_q.size() != 0) @(posedge aclk);
        repeat (LINE_DRAIN) @(posedge aclk);
    endtask

    task automatic apply_config(input logic [MODE_BITS-1:0] mode,
                                input logic [WSIZE_BITS-1:0] ws,
                                input logic [DIM_BITS-1:0] w,
                                input logic [DIM_BITS-1:0] h,
                                input bit junk);
        logic [CFG_DATA_BITS-1:0] vals [4];
        logic [CFG_DATA_BITS-1:0] noise;
        cfg_reg_t                 idx;
        noise = junk ? CFG_DATA_BITS'($urandom) : '0;
        vals[REG_POOL_MODE]   = {noise[CFG_DATA_BITS-1:MODE_BITS], mode};
        vals[REG_WINDOW_SIZE] = {noise[CFG_DATA_BITS-1:WSIZE_BITS], ws};
        vals[REG_MAP_WIDTH]   = w;
        vals[REG_MAP_HEIGHT]  = h;
        idx = idx.first();
        do begin
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= vals[idx];
            @(posedge aclk);
            sb.configure(idx, vals[idx]);
            idx = idx.next();
        end while (idx != idx.first());
        cfg_we <= 1'b0;
    endtask

    task automatic push_repeat(input logic [15:0] v, input int unsigned n);
        repeat (n) push_sample(v);
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'(int'($urandom_range(0, 32)) - 16);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_phase(input bit wide);
        logic [MODE_BITS-1:0]  mode;
        logic [WSIZE_BITS-1:0] ws;
        logic [DIM_BITS-1:0]   w, h;
        logic [15:0]           level;
        int unsigned           area, count;
        bit                    junk, flat;
        mode = MODE_BITS'($urandom_range(0, 3));
        junk = ($urandom_range(0, 3) == 0);
        flat = ($urandom_range(0, 4) == 0);
        level = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        if (wide) begin
            ws    = WSIZE_BITS'($urandom_range(0, 1));
            w     = DIM_BITS'($urandom_range(MAP_WIDTH_MAX, 2047));
            h     = DIM_BITS'($urandom_range(0, 1));
            flat  = 1'b0;
            count = MAP_WIDTH_MAX + $urandom_range(1, 8);
        end else begin
            case ($urandom_range(0, 9))
                0:       ws = '0;
                1:       ws = WSIZE_BITS'($urandom_range(WINDOW_MAX + 1, 15));
                2, 3:    ws = WSIZE_BITS'($urandom_range(5, WINDOW_MAX));
                default: ws = WSIZE_BITS'($urandom_range(1, 4));
            endcase
            if (ws > 4 && ws <= WINDOW_MAX) begin
                w = DIM_BITS'($urandom_range(ws, 16));
                h = DIM_BITS'($urandom_range(ws, 16));
            end else begin
                w = DIM_BITS'($urandom_range(1, 12));
                h = DIM_BITS'($urandom_range(1, 12));
            end
            if ($urandom_range(0, 7) == 0) w = '0;
            if ($urandom_range(0, 7) == 0) h = '0;
            area = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
            if ($urandom_range(0, 15) == 0) begin
                h     = DIM_BITS'($urandom_range(HEIGHT_LIMIT + 1, 2047));
                count = (w == 0 ? 1 : w) * 9;
            end else begin
                count = area * (area <= 48 ? $urandom_range(1, 3) : 1);
                if ($urandom_range(0, 3) == 0) count += $urandom_range(1, area);
            end
        end
        drain_block();
        apply_config(mode, ws, w, h, junk);
        if (wide) hold_req = 1'b1;
        repeat (count) begin
            push_sample(flat ? level : rand_sample());
            random_sent++;
        end
    endtask

    initial begin
        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (4) @(posedge aclk);

        apply_config(MODE_AVG, 4'd2, 11'd2, 11'd2, 1'b0);
        push_repeat(16'h7fff, 4);
        push_repeat(16'h8000, 4);
        push_sample(16'hfffd);
        push_repeat(16'h0000, 3);

        drain_block();
        apply_config(MODE_MAX, 4'd0, 11'd0, 11'd0, 1'b0);
        push_sample(16'h7fff);
        push_sample(16'h8000);

        drain_block();
        apply_config(MODE_MIN, 4'd2, 11'd2, 11'd2, 1'b0);
        push_sample(16'h0005);
        push_sample(16'h8000);
        push_sample(16'h7fff);
        push_sample(16'h0000);

        drain_block();
        apply_config(MODE_SPARE, 4'd2, 11'd2, 11'd2, 1'b0);
        push_sample(16'h0001);
        push_sample(16'h0002);
        push_sample(16'h0003);
        push_sample(16'hffff);

        // The window is wider and taller than the map, so nothing comes out.
        drain_block();
        apply_config(MODE_SPARE, 4'd15, 11'd3, 11'd3, 1'b0);
        push_repeat(16'h1234, 3);

        run_phase(1'b1);
        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent + CALM_ITEMS >= RANDOM_ITEMS) calm = 1'b1;
            run_phase(1'b0);
        end
        drain_block();

        if (sb.errors == 0 && sb.pooled_q.size() == 0) begin
            $display("pooling_2d_forward verification clean");
        end else begin
            $display("pooling_2d_forward verification failed");
        end
        $finish;
    end

endmodule
